// ----- design/wbps_pkg.sv -----
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; every other design file imports this package.
package wbps_pkg;

  localparam int PATTERN_REG_BYTES = 32;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int HITS_W = 10;
  localparam int LEN_W = 6;

  localparam logic [2:0] REG_PATTERN_0 = 3'd0;
  localparam logic [2:0] REG_PATTERN_1 = 3'd1;
  localparam logic [2:0] REG_PATTERN_2 = 3'd2;
  localparam logic [2:0] REG_PATTERN_3 = 3'd3;
  localparam logic [2:0] REG_WILDCARD_MASK = 3'd4;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd5;
  localparam logic [2:0] REG_MAX_HITS = 3'd6;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 6'd1;
  localparam logic [HITS_W-1:0] MAX_HITS_RESET = 10'd10;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [HITS_W-1:0] max_hits;
  } scan_ctrl_t;

  typedef struct packed {
    logic [31:0] addr;
    logic last;
    logic fresh;
  } byte_info_t;

endpackage

// ----- design/wbps_cfg.sv -----
// Configuration registers behind the APB port, plus the pattern realigned to window slots.
// Depends on wbps_pkg.
module wbps_cfg #(
  parameter int WIN = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [wbps_pkg::ADDR_W-1:0] paddr,
  input  logic [wbps_pkg::DATA_W-1:0] pwdata,
  output logic [wbps_pkg::DATA_W-1:0] prdata,
  output logic pready,
  output wbps_pkg::scan_ctrl_t ctrl,
  output logic [WIN-1:0][7:0] expect_byte,
  output logic [WIN-1:0] care
);
  import wbps_pkg::*;

  logic [3:0][63:0] pattern;
  logic [31:0] wildcard_mask;
  logic [LEN_W-1:0] pattern_length;
  logic [HITS_W-1:0] max_hits;
  logic [2:0] reg_index;
  logic write_en;
  logic [LEN_W-1:0] len_eff;
  logic [255:0] pattern_flat;
  logic [WIN-1:0][7:0] expect_next;
  logic [WIN-1:0] care_next;

  assign pready = 1'b1;
  assign reg_index = paddr[5:3];
  assign write_en = psel && penable && pwrite;
  assign pattern_flat = pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      wildcard_mask <= '0;
      pattern_length <= PATTERN_LENGTH_RESET;
      max_hits <= MAX_HITS_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_PATTERN_0: pattern[0] <= pwdata;
        REG_PATTERN_1: pattern[1] <= pwdata;
        REG_PATTERN_2: pattern[2] <= pwdata;
        REG_PATTERN_3: pattern[3] <= pwdata;
        REG_WILDCARD_MASK: wildcard_mask <= pwdata[31:0];
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        REG_MAX_HITS: max_hits <= pwdata[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PATTERN_0: prdata = pattern[0];
      REG_PATTERN_1: prdata = pattern[1];
      REG_PATTERN_2: prdata = pattern[2];
      REG_PATTERN_3: prdata = pattern[3];
      REG_WILDCARD_MASK: prdata = {32'd0, wildcard_mask};
      REG_PATTERN_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_length};
      REG_MAX_HITS: prdata = {{(DATA_W-HITS_W){1'b0}}, max_hits};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(WIN)) begin
      len_eff = LEN_W'(WIN);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Window slot 0 holds the newest byte, which meets pattern byte len-1.
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int s = 0; s < WIN; s++) begin
      idx = len_eff - LEN_W'(s) - LEN_W'(1);
      expect_next[s] = pattern_flat[idx[4:0]*8 +: 8];
      care_next[s] = (LEN_W'(s) < len_eff) && !wildcard_mask[idx[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    expect_byte <= expect_next;
    care <= care_next;
    if (rst) begin
      ctrl <= '{len: PATTERN_LENGTH_RESET, max_hits: MAX_HITS_RESET};
    end else begin
      ctrl <= '{len: len_eff, max_hits: max_hits};
    end
  end

endmodule

// ----- design/wbps_window.sv -----
// Input stage: shift window of recent bytes and the registered byte information.
// Depends on wbps_pkg.
module wbps_window #(
  parameter int WIN = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic take,
  input  logic [7:0] data_byte,
  input  wbps_pkg::byte_info_t info_in,
  output logic held,
  output wbps_pkg::byte_info_t info,
  output logic [WIN-1:0][7:0] window
);
  import wbps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  // Slots are only compared once the run count shows they were written.
  always_ff @(posedge clk) begin
    if (accept) begin
      info <= info_in;
      for (int s = WIN - 1; s > 0; s--) begin
        window[s] <= window[s-1];
      end
      window[0] <= data_byte;
    end
  end

endmodule

// ----- design/wbps_match.sv -----
// Compare stage: window against aligned pattern, run and hit counters, result register.
// Depends on wbps_pkg.
module wbps_match #(
  parameter int WIN = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic held,
  input  wbps_pkg::byte_info_t info,
  input  logic [WIN-1:0][7:0] window,
  input  wbps_pkg::scan_ctrl_t ctrl,
  input  logic [WIN-1:0][7:0] expect_byte,
  input  logic [WIN-1:0] care,
  output logic take,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] match_addr,
  output logic [wbps_pkg::HITS_W-1:0] hit_index
);
  import wbps_pkg::*;

  localparam int CW = $clog2(WIN + 1);

  logic [CW-1:0] usable_count;
  logic [CW-1:0] usable_prev;
  logic [CW-1:0] usable_now;
  logic [HITS_W-1:0] hit_count;
  logic [HITS_W-1:0] hit_base;
  logic [WIN-1:0] slot_ok;
  logic found;
  logic emit;

  assign take = held && (!out_valid || out_ready);

  always_comb begin
    for (int s = 0; s < WIN; s++) begin
      slot_ok[s] = !care[s] || (window[s] == expect_byte[s]);
    end
    usable_prev = info.fresh ? '0 : usable_count;
    usable_now = (usable_prev < CW'(WIN)) ? usable_prev + CW'(1) : usable_prev;
    hit_base = info.fresh ? '0 : hit_count;
    found = (7'(usable_now) >= 7'(ctrl.len)) && (&slot_ok);
    emit = found && (hit_base < ctrl.max_hits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_count <= '0;
      hit_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        usable_count <= (found || info.last) ? '0 : usable_now;
        hit_count <= emit ? hit_base + HITS_W'(1) : hit_base;
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      match_addr <= info.addr - (32'(ctrl.len) - 32'd1);
      hit_index <= hit_base;
    end
  end

endmodule

// ----- design/wildcard_byte_pattern_scanner_top.sv -----
// Top level of the wildcard byte pattern scanner: APB registers, input window, compare stage.
// Depends on wbps_pkg, wbps_cfg, wbps_window and wbps_match.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     data_byte, byte_addr, last_in_region, new_scan
//   result    out_valid / out_ready   match_addr, hit_index
//   config    APB psel/penable/pwrite paddr, pwdata, prdata (64-bit registers at 8*i)
//
// One byte is accepted every cycle while in_ready stays high; a byte is first registered in
// the window register, then its result in the compare-and-count stage.
// Reset is synchronous and clears the valid flags, counters and configuration registers; no clearing pass.
// When a result waits on out_ready, one more byte is held in the window stage before
// in_ready drops.
module wildcard_byte_pattern_scanner_top #(
  parameter int PATTERN_MAX = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] data_byte,
  input  logic [31:0] byte_addr,
  input  logic last_in_region,
  input  logic new_scan,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] match_addr,
  output logic [wbps_pkg::HITS_W-1:0] hit_index,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [wbps_pkg::ADDR_W-1:0] paddr,
  input  logic [wbps_pkg::DATA_W-1:0] pwdata,
  output logic [wbps_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  import wbps_pkg::*;

  localparam int WIN = (PATTERN_MAX < PATTERN_REG_BYTES) ? PATTERN_MAX : PATTERN_REG_BYTES;

  scan_ctrl_t ctrl;
  logic [WIN-1:0][7:0] expect_byte;
  logic [WIN-1:0] care;
  logic [WIN-1:0][7:0] window;
  byte_info_t info_in;
  byte_info_t info;
  logic held;
  logic take;
  logic accept;

  assign in_ready = !held || take;
  assign accept = in_valid && in_ready;
  assign info_in = '{addr: byte_addr, last: last_in_region, fresh: new_scan};

  wbps_cfg #(.WIN(WIN)) u_cfg (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .ctrl(ctrl), .expect_byte(expect_byte), .care(care)
  );

  wbps_window #(.WIN(WIN)) u_window (
    .clk(clk), .rst(rst),
    .accept(accept), .take(take),
    .data_byte(data_byte), .info_in(info_in),
    .held(held), .info(info), .window(window)
  );

  wbps_match #(.WIN(WIN)) u_match (
    .clk(clk), .rst(rst),
    .held(held), .info(info), .window(window),
    .ctrl(ctrl), .expect_byte(expect_byte), .care(care),
    .take(take), .out_valid(out_valid), .out_ready(out_ready),
    .match_addr(match_addr), .hit_index(hit_index)
  );

endmodule

// ----- sim/tb_wildcard_byte_pattern_scanner_top.sv -----
// Testbench for wildcard_byte_pattern_scanner_top: a directed table, then random scans.
// Results are checked against a built-in predictor. Depends on wbps_pkg and the design files.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_top;
  import wbps_pkg::*;

  localparam int PATTERN_MAX = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_HIT, CHK_NONE} row_check_t;

  typedef struct packed {
    row_kind_t kind;
    row_check_t chk;
    logic [2:0] reg_idx;
    logic [63:0] value;
    logic [7:0] data;
    logic [31:0] addr;
    logic last;
    logic fresh;
    logic [31:0] exp_addr;
    logic [HITS_W-1:0] exp_idx;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [HITS_W-1:0] idx;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic [31:0] byte_addr = '0;
  logic last_in_region = 1'b0;
  logic new_scan = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] match_addr;
  logic [HITS_W-1:0] hit_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [63:0] pat_reg [4] = '{default: '0};
  logic [31:0] wmask = '0;
  logic [LEN_W-1:0] len_reg = PATTERN_LENGTH_RESET;
  logic [HITS_W-1:0] max_hits_reg = MAX_HITS_RESET;
  logic [7:0] win [PATTERN_MAX] = '{default: '0};
  int unsigned usable = 0;
  logic [HITS_W-1:0] hit_cnt = '0;

  hit_t pending_hits [$];
  dir_row_t dir_rows [$];
  int mismatches = 0;
  int cycle_count = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int ready_wait = 0;

  wildcard_byte_pattern_scanner_top #(.PATTERN_MAX(PATTERN_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .byte_addr(byte_addr),
    .last_in_region(last_in_region),
    .new_scan(new_scan),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .match_addr(match_addr),
    .hit_index(hit_index),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wildcard_byte_pattern_scanner_top test failed");
      $finish;
    end
  end

  function automatic logic [7:0] pat_byte(input int i);
    return pat_reg[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic bit predict_match(input logic [7:0] d, input logic [31:0] a,
                                       input bit last, input bit fresh,
                                       output logic [31:0] m_addr,
                                       output logic [HITS_W-1:0] m_idx);
    int len_eff;
    int i;
    bit match;
    len_eff = (len_reg == 0) ? 1 : ((len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg));
    m_addr = '0;
    m_idx = '0;
    if (fresh) begin
      hit_cnt = '0;
      usable = 0;
      for (i = 0; i < PATTERN_MAX; i++) win[i] = '0;
    end
    for (i = PATTERN_MAX - 1; i > 0; i--) win[i] = win[i - 1];
    win[0] = d;
    if (usable < PATTERN_MAX) usable++;
    match = (usable >= len_eff);
    for (i = 0; i < len_eff; i++) begin
      if (!wmask[i] && win[len_eff - 1 - i] != pat_byte(i)) match = 1'b0;
    end
    if (match) begin
      usable = 0;
      if (hit_cnt < max_hits_reg) begin
        m_addr = a - 32'(len_eff - 1);
        m_idx = hit_cnt;
        hit_cnt++;
      end else begin
        match = 1'b0;
      end
    end
    if (last) usable = 0;
    return match;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [63:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] d, input logic [31:0] a,
                                        input bit last, input bit fresh,
                                        input row_check_t chk = CHK_MODEL,
                                        input logic [31:0] ea = '0,
                                        input logic [HITS_W-1:0] ei = '0);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.chk = chk;
    r.data = d;
    r.addr = a;
    r.last = last;
    r.fresh = fresh;
    r.exp_addr = ea;
    r.exp_idx = ei;
    return r;
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PATTERN_0: pat_reg[0] = val;
      REG_PATTERN_1: pat_reg[1] = val;
      REG_PATTERN_2: pat_reg[2] = val;
      REG_PATTERN_3: pat_reg[3] = val;
      REG_WILDCARD_MASK: wmask = val[31:0];
      REG_PATTERN_LENGTH: len_reg = val[LEN_W-1:0];
      REG_MAX_HITS: max_hits_reg = val[HITS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] d, input logic [31:0] a, input bit last,
                           input bit fresh, input row_check_t chk,
                           input logic [31:0] ea, input logic [HITS_W-1:0] ei);
    int gap;
    bit hit;
    hit_t want;
    logic [31:0] p_addr;
    logic [HITS_W-1:0] p_idx;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    byte_addr <= a;
    last_in_region <= last;
    new_scan <= fresh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = predict_match(d, a, last, fresh, p_addr, p_idx);
    case (chk)
      CHK_MODEL: begin
        if (hit) begin
          want.addr = p_addr;
          want.idx = p_idx;
          pending_hits.insert(pending_hits.size(), want);
        end
      end
      CHK_HIT: begin
        want.addr = ea;
        want.idx = ei;
        pending_hits.insert(pending_hits.size(), want);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [63:0] v;
    reg_write(REG_PATTERN_0, {$urandom, $urandom});
    reg_write(REG_PATTERN_1, {$urandom, $urandom});
    reg_write(REG_PATTERN_2, {$urandom, $urandom});
    reg_write(REG_PATTERN_3, {$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = 64'hFFFF_FFFF;
      default: v = 64'($urandom & $urandom);
    endcase
    reg_write(REG_WILDCARD_MASK, v);
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = 64'd32;
      2: v = 64'($urandom_range(33, 63));
      3: v = 64'($urandom_range(7, 31));
      default: v = 64'($urandom_range(1, 6));
    endcase
    reg_write(REG_PATTERN_LENGTH, v);
    case ($urandom_range(0, 5))
      0: v = 64'd0;
      1: v = 64'd1023;
      2: v = 64'($urandom_range(1, 4));
      default: v = 64'($urandom_range(5, 1022));
    endcase
    reg_write(REG_MAX_HITS, v);
  endtask

  task automatic random_scan(input int n_items);
    int sent;
    int len_eff;
    int kind;
    int run;
    int pos;
    int i;
    logic [7:0] b;
    logic [31:0] addr;
    bit last;
    bit fresh;
    len_eff = (len_reg == 0) ? 1 : ((len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg));
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    addr = $urandom;
    fresh = $urandom_range(0, 1);
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      run = (kind < 8) ? len_eff : $urandom_range(1, 4);
      pos = $urandom_range(0, run - 1);
      for (i = 0; i < run; i++) begin
        if (kind < 8) begin
          b = wmask[i] ? 8'($urandom) : pat_byte(i);
        end else begin
          b = $urandom_range(0, 1) ? pat_byte($urandom_range(0, len_eff - 1)) : 8'($urandom);
        end
        if (kind == 6 && i == pos) b = b ^ (8'h01 << $urandom_range(0, 7));
        last = (kind == 7 && i == pos) || (i == run - 1 && $urandom_range(0, 7) == 0);
        send_byte(b, addr, last, fresh, CHK_MODEL, '0, '0);
        fresh = ($urandom_range(0, 199) == 0);
        addr = last ? 32'($urandom) : addr + 1;
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      ready_wait = rx_calm ? 0 : $urandom_range(0, 6);
      out_ready <= (ready_wait == 0);
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_ready <= (ready_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hit_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected match: expected none, got addr %h index %0d",
                 $time, match_addr, hit_index);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (want.addr !== match_addr) begin
          $display("%0t: match_addr expected %h, got %h", $time, want.addr, match_addr);
          mismatches++;
        end
        if (want.idx !== hit_index) begin
          $display("%0t: hit_index expected %0d, got %0d", $time, want.idx, hit_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    logic [31:0] addr;
    int n;
    int ph;

    add_row(byte_row(8'h00, 32'h0000_0000, 0, 1, CHK_HIT, 32'h0000_0000, 0));
    add_row(byte_row(8'hFF, 32'h0000_0001, 0, 0, CHK_NONE));
    add_row(byte_row(8'h00, 32'hFFFF_FFFF, 1, 0, CHK_HIT, 32'hFFFF_FFFF, 1));
    add_row(cfg_row(REG_MAX_HITS, 2));
    add_row(byte_row(8'h00, 32'h0000_0100, 0, 0, CHK_NONE));
    add_row(byte_row(8'h00, 32'h0000_0101, 0, 1, CHK_HIT, 32'h0000_0101, 0));
    add_row(cfg_row(REG_MAX_HITS, 0));
    add_row(byte_row(8'h00, 32'h0000_0200, 0, 1, CHK_NONE));
    add_row(cfg_row(REG_MAX_HITS, 1023));
    add_row(cfg_row(REG_PATTERN_LENGTH, 0));
    add_row(cfg_row(REG_PATTERN_0, 64'h0000_0000_0000_00AB));
    add_row(byte_row(8'hAB, 32'h0000_0300, 0, 1, CHK_HIT, 32'h0000_0300, 0));
    add_row(cfg_row(REG_PATTERN_LENGTH, 3));
    add_row(cfg_row(REG_PATTERN_0, 64'h0000_0000_0056_3412));
    add_row(cfg_row(REG_WILDCARD_MASK, 32'h0000_0002));
    add_row(byte_row(8'h12, 32'h0000_0000, 0, 1));
    add_row(byte_row(8'h99, 32'h0000_0001, 0, 0));
    add_row(byte_row(8'h56, 32'h0000_0002, 0, 0));
    add_row(byte_row(8'h12, 32'h0000_0010, 0, 0));
    add_row(byte_row(8'h34, 32'h0000_0011, 1, 0));
    add_row(byte_row(8'h56, 32'h0000_0012, 0, 0));
    add_row(byte_row(8'h12, 32'h0000_0020, 0, 0));
    add_row(byte_row(8'h00, 32'h0000_0021, 0, 0));
    add_row(byte_row(8'h56, 32'h0000_0022, 1, 0));
    add_row(cfg_row(REG_PATTERN_LENGTH, 2));
    add_row(cfg_row(REG_PATTERN_0, 64'h0000_0000_0000_AAAA));
    add_row(cfg_row(REG_WILDCARD_MASK, 32'h0000_0000));
    add_row(byte_row(8'hAA, 32'h0000_0040, 0, 1));
    add_row(byte_row(8'hAA, 32'h0000_0041, 0, 0));
    add_row(byte_row(8'hAA, 32'h0000_0042, 0, 0));
    add_row(byte_row(8'hAA, 32'h0000_0043, 0, 0));
    add_row(byte_row(8'hAA, 32'hFFFF_FFFF, 0, 1));
    add_row(byte_row(8'hAA, 32'h0000_0000, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        drain();
        reg_write(row.reg_idx, row.value);
      end else begin
        send_byte(row.data, row.addr, row.last, row.fresh, row.chk, row.exp_addr, row.exp_idx);
      end
    end

    // Every byte matches here, so the hit index runs up to 1022 and the rest are dropped.
    drain();
    reg_write(REG_PATTERN_LENGTH, 1);
    reg_write(REG_WILDCARD_MASK, 64'($urandom | 32'h1));
    reg_write(REG_MAX_HITS, 1023);
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    hold_req = 1'b1;
    addr = $urandom;
    for (n = 0; n < 1030; n++) begin
      if (n == 100) tx_calm = 1'b0;
      send_byte(8'($urandom), addr, 0, n == 0, CHK_MODEL, '0, '0);
      addr++;
    end

    for (ph = 0; ph < 9; ph++) begin
      drain();
      random_config();
      random_scan(90);
    end

    drain();
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("wildcard_byte_pattern_scanner_top test passed");
    end else begin
      $display("wildcard_byte_pattern_scanner_top test failed");
    end
    $finish;
  end

endmodule
